@@ hw/rtl/pcmdm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the PCM to mono downmix block: widths, register indexes,
// sample format codes, sequencer states and the divider status struct.
// No dependencies.
package pcmdm_pkg;

    // Fixed widths of the fields and registers
    localparam int SAMPLE_W   = 32;
    localparam int MONO_W     = 32;
    localparam int FMT_W      = 3;
    localparam int CNT_W      = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    // Default frame size limit
    localparam int MAX_CHANNELS_DEF = 8;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 1'd1;

    // Reset values of the registers
    localparam logic [FMT_W-1:0] FORMAT_RESET = 3'd1;
    localparam logic [CNT_W-1:0] COUNT_RESET  = 4'd1;

    // Float32 exponent at which the mantissa needs no shift for Q1.31
    localparam logic [7:0] F32_EXP_ALIGN = 8'd119;
    localparam logic [7:0] F32_EXP_ONE   = 8'd127;
    localparam logic [7:0] F32_EXP_MAX   = 8'hFF;
    localparam logic [7:0] F32_RSH_LIMIT = 8'd24;

    typedef enum logic [FMT_W-1:0] {
        FMT_U8  = 3'd0,
        FMT_S16 = 3'd1,
        FMT_S24 = 3'd2,
        FMT_S32 = 3'd3,
        FMT_F32 = 3'd4
    } t_fmt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_LOAD,
        ST_DIVIDE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

@@ hw/rtl/pcmdm_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the raw sample input and the mono output.
// Depends on pcmdm_pkg.
interface pcmdm_in_if;
    import pcmdm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_bytes;

    modport source (output valid, output sample_bytes, input ready);
    modport sink   (input valid, input sample_bytes, output ready);
endinterface

interface pcmdm_out_if;
    import pcmdm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [MONO_W-1:0] mono_sample;

    modport source (output valid, output mono_sample, input ready);
    modport sink   (input valid, input mono_sample, output ready);
endinterface

@@ hw/rtl/pcm_to_mono_downmix_top.sv @@
`timescale 1ns / 1ps
// PCM to mono downmix: format conversion, frame accumulation, serial average.
// Depends on pcmdm_pkg, pcmdm_if, pcmdm_convert and pcmdm_divider.
//
// Usage:
//   i_sample_if carries one raw little-endian channel sample per transaction,
//   channels of a frame interleaved. o_mono_if carries one signed Q1.31
//   sample per frame: the frame sum divided by the channel count, truncated
//   toward zero. The configuration port writes sample_format (index 0) and
//   channel_count (index 1); write them only while no frame result is pending.
//   Each accepted sample is captured, then converted and accumulated, before the
//   input is ready again. The last sample of a frame adds a load state plus
//   the serial divider, one quotient bit per cycle over the 32 +
//   clog2(MAX_CHANNELS) bit sum (35 bits at the default), and the input is
//   ready again in the same cycle that the frame result appears.
//   A finished result waits in the output register; if the receiver stalls
//   while the next frame result is ready, the divider holds that result and
//   the input stays not ready until the output register frees up.
//   Reset (synchronous, active low) restores sample_format to s16,
//   channel_count to 1, and clears the frame sum and channel index.
module pcm_to_mono_downmix_top import pcmdm_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pcmdm_in_if.sink              i_sample_if,
    pcmdm_out_if.source           o_mono_if
);

    localparam int SUM_W = MONO_W + $clog2(MAX_CHANNELS);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    t_state                   r_state, n_state;
    logic [FMT_W-1:0]         r_format;
    logic [CNT_W-1:0]         r_count_cfg;
    logic [SAMPLE_W-1:0]      r_sample;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [IDX_W-1:0]         r_index, n_index;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid;
    logic signed [MONO_W-1:0] r_out_data;

    logic                     in_accept;
    logic signed [MONO_W-1:0] conv_value;
    logic [CNT_W-1:0]         eff_count;
    logic [IDX_W:0]           index_next;
    logic                     frame_last;
    logic                     div_start;
    logic                     out_load;
    logic                     out_free;
    t_div_status              div_status;
    logic signed [MONO_W-1:0] div_quotient;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FORMAT_RESET;
            r_count_cfg <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SAMPLE_FORMAT: r_format    <= i_cfg_wdata[FMT_W-1:0];
                REG_CHANNEL_COUNT: r_count_cfg <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    pcmdm_convert u_convert (
        .i_format (r_format),
        .i_raw    (r_sample),
        .o_value  (conv_value)
    );

    pcmdm_divider #(
        .SUM_W (SUM_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .i_take     (out_load),
        .o_status   (div_status),
        .o_quotient (div_quotient)
    );

    // Clamp the channel count to 1..MAX_CHANNELS
    always_comb begin
        if (r_count_cfg == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(r_count_cfg) > MAX_CHANNELS) begin
            eff_count = CNT_W'(MAX_CHANNELS);
        end else begin
            eff_count = r_count_cfg;
        end
        index_next = {1'b0, r_index} + 1'b1;
        frame_last = 8'(index_next) >= 8'(eff_count);
    end

    assign in_accept = i_sample_if.valid && i_sample_if.ready;
    assign out_free  = !r_out_valid || o_mono_if.ready;

    // Sequencer: capture, accumulate, start divide, hand off result
    always_comb begin
        n_state   = r_state;
        n_sum     = r_sum;
        n_index   = r_index;
        n_count   = r_count;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                n_sum = r_sum + SUM_W'(conv_value);
                if (frame_last) begin
                    n_index = '0;
                    n_count = eff_count;
                    n_state = ST_LOAD;
                end else begin
                    n_index = index_next[IDX_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD: begin
                div_start = 1'b1;
                n_sum     = '0;
                n_state   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_status.done && out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_index     <= '0;
            r_count     <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_index <= n_index;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_mono_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample_if.sample_bytes;
        end
        if (out_load) begin
            r_out_data <= div_quotient;
        end
    end

    assign i_sample_if.ready     = (r_state == ST_IDLE);
    assign o_mono_if.valid       = r_out_valid;
    assign o_mono_if.mono_sample = r_out_data;

endmodule

@@ hw/rtl/pcmdm_convert.sv @@
`timescale 1ns / 1ps
// Sample format converter: raw little-endian word to signed Q1.31.
// Depends on pcmdm_pkg.
module pcmdm_convert import pcmdm_pkg::*; (
    input  logic [FMT_W-1:0]         i_format,
    input  logic [SAMPLE_W-1:0]      i_raw,
    output logic signed [MONO_W-1:0] o_value
);

    logic              f_neg;
    logic [7:0]        f_exp;
    logic [23:0]       f_mant;
    logic [7:0]        f_lsh;
    logic [7:0]        f_rsh;
    logic [MONO_W-1:0] f_mag;
    logic [MONO_W-1:0] f_value;

    // Float32: scale by 2^31, truncate toward zero, saturate at one
    always_comb begin
        f_neg  = i_raw[31];
        f_exp  = i_raw[30:23];
        f_mant = {1'b1, i_raw[22:0]};
        f_lsh  = f_exp - F32_EXP_ALIGN;
        f_rsh  = F32_EXP_ALIGN - f_exp;
        if (f_exp >= F32_EXP_ALIGN) begin
            f_mag = {8'd0, f_mant} << f_lsh[2:0];
        end else if (f_rsh >= F32_RSH_LIMIT) begin
            f_mag = '0;
        end else begin
            f_mag = {8'd0, f_mant >> f_rsh[4:0]};
        end
        if (f_exp == F32_EXP_MAX || f_exp == 8'd0) begin
            f_value = '0;
        end else if (f_exp >= F32_EXP_ONE) begin
            f_value = f_neg ? {1'b1, {(MONO_W-1){1'b0}}} : {1'b0, {(MONO_W-1){1'b1}}};
        end else begin
            f_value = f_neg ? (~f_mag + 1'b1) : f_mag;
        end
    end

    // Select by format; unused codes contribute zero
    always_comb begin
        case (t_fmt'(i_format))
            FMT_U8:  o_value = {~i_raw[7], i_raw[6:0], 24'd0};
            FMT_S16: o_value = {i_raw[15:0], 16'd0};
            FMT_S24: o_value = {i_raw[23:0], 8'd0};
            FMT_S32: o_value = i_raw;
            FMT_F32: o_value = f_value;
            default: o_value = '0;
        endcase
    end

endmodule

@@ hw/rtl/pcmdm_divider.sv @@
`timescale 1ns / 1ps
// Serial restoring divider: signed frame sum by channel count, one quotient
// bit per cycle, truncated toward zero. Depends on pcmdm_pkg.
module pcmdm_divider import pcmdm_pkg::*; #(
    parameter int SUM_W = MONO_W + $clog2(MAX_CHANNELS_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]         i_divisor,
    input  logic                     i_take,
    output t_div_status              o_status,
    output logic signed [MONO_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(SUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [SUM_W-1:0]  r_num, n_num;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_div, n_div;
    logic              r_neg, n_neg;
    logic [CNT_W:0]    trial;
    logic              fits;

    // Shift one dividend bit into the remainder and try the subtract
    always_comb begin
        trial  = {r_rem, r_num[SUM_W-1]};
        fits   = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = r_done;
        n_step = r_step;
        n_num  = r_num;
        n_rem  = r_rem;
        n_div  = r_div;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_step = STEPS;
            n_neg  = i_dividend[SUM_W-1];
            n_num  = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = fits ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
            n_num  = {r_num[SUM_W-2:0], fits};
            n_step = r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_take) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    // Restore the sign on the low word of the magnitude quotient
    assign o_quotient    = r_neg ? (~r_num[MONO_W-1:0] + 1'b1) : r_num[MONO_W-1:0];
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

@@ hw/rtl/pcmdm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the downmix top level, attached by bind.
// Depends on pcmdm_pkg and pcm_to_mono_downmix_top.
module pcmdm_checker import pcmdm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [MONO_W-1:0] i_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // Output channel is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output payload changed while stalled");

    // Busy in the cycle after each accepted sample
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // A new result never rises right after an accepted sample
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
        else $error("result appeared too soon after a sample");

endmodule

bind pcm_to_mono_downmix_top pcmdm_checker u_pcmdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_if.valid),
    .i_in_ready  (i_sample_if.ready),
    .i_out_valid (o_mono_if.valid),
    .i_out_ready (o_mono_if.ready),
    .i_out_data  (o_mono_if.mono_sample)
);
